>>> src/ppcr_pkg.sv
// ppcr_pkg: shared types and constants of the particle pair collision resolver
// no dependencies; imported by every module under src

package ppcr_pkg;

   localparam int SqrtStages  = 32;
   localparam int NormStages  = 17;
   localparam int ShareStages = 33;
   localparam int MinDist     = 66;
   localparam int FxOne       = 65536;
   localparam int CsrAddrBits = 3;

   localparam logic [16:0] RelaxReset = 17'd6554;

   // register index codes, taken from paddr[2]
   localparam logic RegRelaxation = 1'b0;

   typedef struct packed {
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic [30:0]        a_radius;
      logic [30:0]        b_radius;
      logic signed [31:0] a_mass;
      logic signed [31:0] b_mass;
      logic               a_enabled;
      logic               b_enabled;
   } pair_type;

   typedef struct packed {
      logic signed [31:0] new_a_x;
      logic signed [31:0] new_a_y;
      logic signed [31:0] new_b_x;
      logic signed [31:0] new_b_y;
      logic               corrected;
   } result_type;

   // geometry after the front stages
   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] adx;
      logic [31:0] ady;
      logic        negx;
      logic        negy;
      logic [31:0] rs;
      logic        hit;
      logic [63:0] s;
   } geo_type;

   // normal and push length, ready for the mass split
   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [16:0] nx;
      logic [16:0] ny;
      logic        negx;
      logic        negy;
      logic [32:0] delta;
      logic        hit;
   } mid_type;

endpackage

>>> src/ppcr_front.sv
// ppcr_front: register stages of differences, squares and the overlap compare
// depends on ppcr_pkg

module ppcr_front import ppcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pair_type in_pair,
   output logic     out_valid,
   output geo_type  out_geo
);

   logic [3:0]  vld_ff;
   pair_type    p0_ff, p1_ff, p2_ff, p3_ff;
   logic [32:0] dx0_ff, dy0_ff;
   logic [31:0] rs0_ff, rs1_ff, rs2_ff, rs3_ff;
   logic [31:0] adx1_ff, ady1_ff, adx2_ff, ady2_ff, adx3_ff, ady3_ff;
   logic        negx1_ff, negy1_ff, negx2_ff, negy2_ff, negx3_ff, negy3_ff;
   logic [63:0] rsq2_ff, rsq3_ff, sx3_ff, sy3_ff;
   logic [63:0] rsq1_ff;

   logic [32:0] dx_in, dy_in;
   logic [31:0] rs_in;
   logic [31:0] adx_in, ady_in;
   logic [64:0] s_sum;

   assign dx_in  = {in_pair.a_pos_x[31], in_pair.a_pos_x} - {in_pair.b_pos_x[31], in_pair.b_pos_x};
   assign dy_in  = {in_pair.a_pos_y[31], in_pair.a_pos_y} - {in_pair.b_pos_y[31], in_pair.b_pos_y};
   assign rs_in  = {1'b0, in_pair.a_radius} + {1'b0, in_pair.b_radius};
   assign adx_in = dx0_ff[32] ? 32'(33'd0 - dx0_ff) : dx0_ff[31:0];
   assign ady_in = dy0_ff[32] ? 32'(33'd0 - dy0_ff) : dy0_ff[31:0];
   assign s_sum  = {1'b0, sx3_ff} + {1'b0, sy3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      // stage 0: differences and radius sum
      p0_ff  <= in_pair;
      dx0_ff <= dx_in;
      dy0_ff <= dy_in;
      rs0_ff <= rs_in;
      // stage 1: magnitudes and radius square
      p1_ff    <= p0_ff;
      adx1_ff  <= adx_in;
      ady1_ff  <= ady_in;
      negx1_ff <= dx0_ff[32];
      negy1_ff <= dy0_ff[32];
      rs1_ff   <= rs0_ff;
      rsq1_ff  <= 64'(rs0_ff) * 64'(rs0_ff);
      // stage 2: delay; stage 3: squares of the differences
      p2_ff    <= p1_ff;
      adx2_ff  <= adx1_ff;
      ady2_ff  <= ady1_ff;
      negx2_ff <= negx1_ff;
      negy2_ff <= negy1_ff;
      rs2_ff   <= rs1_ff;
      rsq2_ff  <= rsq1_ff;
      p3_ff    <= p2_ff;
      adx3_ff  <= adx2_ff;
      ady3_ff  <= ady2_ff;
      negx3_ff <= negx2_ff;
      negy3_ff <= negy2_ff;
      rs3_ff   <= rs2_ff;
      rsq3_ff  <= rsq2_ff;
      sx3_ff   <= 64'(adx2_ff) * 64'(adx2_ff);
      sy3_ff   <= 64'(ady2_ff) * 64'(ady2_ff);
   end

   // stage 3 output: sum and exact compare against the radius square
   logic        hit_in;
   geo_type     geo_ff;
   logic        ovld_ff;

   assign hit_in = p3_ff.a_enabled && p3_ff.b_enabled && (s_sum < {1'b0, rsq3_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      geo_ff.ax   <= p3_ff.a_pos_x;
      geo_ff.ay   <= p3_ff.a_pos_y;
      geo_ff.bx   <= p3_ff.b_pos_x;
      geo_ff.by   <= p3_ff.b_pos_y;
      geo_ff.ma   <= p3_ff.a_mass;
      geo_ff.mb   <= p3_ff.b_mass;
      geo_ff.adx  <= adx3_ff;
      geo_ff.ady  <= ady3_ff;
      geo_ff.negx <= negx3_ff;
      geo_ff.negy <= negy3_ff;
      geo_ff.rs   <= rs3_ff;
      geo_ff.hit  <= hit_in;
      geo_ff.s    <= s_sum[63:0];
   end

   assign out_valid = ovld_ff;
   assign out_geo   = geo_ff;

endmodule

>>> src/ppcr_sqrt.sv
// ppcr_sqrt: pipelined integer square root, one root bit per stage
// depends on ppcr_pkg

module ppcr_sqrt import ppcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  geo_type     in_geo,
   output logic        out_valid,
   output geo_type     out_geo,
   output logic [31:0] out_dist
);

   logic        vld_ff  [SqrtStages];
   geo_type     geo_ff  [SqrtStages];
   logic [63:0] rem_ff  [SqrtStages];
   logic [31:0] root_ff [SqrtStages];
   logic [63:0] rem_in  [SqrtStages];
   logic [31:0] root_in [SqrtStages];

   always_comb begin
      logic [63:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] trial;
      for (int k = 0; k < SqrtStages; k++) begin
         if (k == 0) begin
            rem_p  = in_geo.s;
            root_p = '0;
         end else begin
            rem_p  = rem_ff[k-1];
            root_p = root_ff[k-1];
         end
         // trial for bit i = 31 - k: (root << (i + 1)) | (1 << 2i)
         trial = (64'(root_p) << (SqrtStages - k)) | (64'd1 << (2 * (SqrtStages - 1 - k)));
         if (rem_p >= trial) begin
            rem_in[k]  = rem_p - trial;
            root_in[k] = root_p | (32'd1 << (SqrtStages - 1 - k));
         end else begin
            rem_in[k]  = rem_p;
            root_in[k] = root_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SqrtStages; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < SqrtStages; k++) vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SqrtStages; k++) begin
         geo_ff[k]  <= (k == 0) ? in_geo : geo_ff[k-1];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = vld_ff[SqrtStages-1];
   assign out_geo   = geo_ff[SqrtStages-1];
   assign out_dist  = root_ff[SqrtStages-1];

endmodule

>>> src/ppcr_normal.sv
// ppcr_normal: push length and unit normal, two dividers one quotient bit per stage
// depends on ppcr_pkg

module ppcr_normal import ppcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  geo_type     in_geo,
   input  logic [31:0] in_dist,
   input  logic [16:0] relax,
   output logic        out_valid,
   output mid_type     out_mid
);

   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] ma;
      logic [31:0] mb;
      logic        negx;
      logic        negy;
      logic        hit;
      logic        near;
      logic [31:0] span;
      logic [31:0] diff;
      logic [32:0] delta;
   } nside_type;

   logic        vld_ff  [NormStages];
   nside_type   side_ff [NormStages];
   logic [31:0] rx_ff   [NormStages];
   logic [31:0] ry_ff   [NormStages];
   logic [16:0] qx_ff   [NormStages];
   logic [16:0] qy_ff   [NormStages];
   nside_type   side_in [NormStages];
   logic [31:0] rx_in   [NormStages];
   logic [31:0] ry_in   [NormStages];
   logic [16:0] qx_in   [NormStages];
   logic [16:0] qy_in   [NormStages];

   always_comb begin
      nside_type   sd;
      logic [31:0] rx_p, ry_p;
      logic [16:0] qx_p, qy_p;
      logic        bit_x, bit_y;
      logic [32:0] tx, ty, dv;
      logic [48:0] prod;
      for (int k = 0; k < NormStages; k++) begin
         if (k == 0) begin
            sd.ax    = in_geo.ax;
            sd.ay    = in_geo.ay;
            sd.bx    = in_geo.bx;
            sd.by    = in_geo.by;
            sd.ma    = in_geo.ma;
            sd.mb    = in_geo.mb;
            sd.negx  = in_geo.negx;
            sd.negy  = in_geo.negy;
            sd.hit   = in_geo.hit;
            sd.near  = in_dist < 32'(MinDist);
            sd.span  = in_dist;
            sd.diff  = in_geo.rs - in_dist;
            sd.delta = '0;
            // dividend is magnitude << 16; top bits seed the remainder
            rx_p  = {1'b0, in_geo.adx[31:1]};
            ry_p  = {1'b0, in_geo.ady[31:1]};
            bit_x = in_geo.adx[0];
            bit_y = in_geo.ady[0];
            qx_p  = '0;
            qy_p  = '0;
         end else begin
            sd    = side_ff[k-1];
            rx_p  = rx_ff[k-1];
            ry_p  = ry_ff[k-1];
            qx_p  = qx_ff[k-1];
            qy_p  = qy_ff[k-1];
            bit_x = 1'b0;
            bit_y = 1'b0;
         end
         // overlap times relaxation, in the second stage
         prod = 49'(sd.diff) * 49'(relax);
         if (k == 1) sd.delta = prod[48:16];
         dv = {1'b0, sd.span};
         tx = {rx_p, bit_x};
         ty = {ry_p, bit_y};
         if (tx >= dv) begin
            rx_in[k] = 32'(tx - dv);
            qx_in[k] = {qx_p[15:0], 1'b1};
         end else begin
            rx_in[k] = tx[31:0];
            qx_in[k] = {qx_p[15:0], 1'b0};
         end
         if (ty >= dv) begin
            ry_in[k] = 32'(ty - dv);
            qy_in[k] = {qy_p[15:0], 1'b1};
         end else begin
            ry_in[k] = ty[31:0];
            qy_in[k] = {qy_p[15:0], 1'b0};
         end
         side_in[k] = sd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NormStages; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < NormStages; k++) vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NormStages; k++) begin
         side_ff[k] <= side_in[k];
         rx_ff[k]   <= rx_in[k];
         ry_ff[k]   <= ry_in[k];
         qx_ff[k]   <= qx_in[k];
         qy_ff[k]   <= qy_in[k];
      end
   end

   nside_type last;
   assign last = side_ff[NormStages-1];

   // centres closer than MinDist take the normal (one, zero)
   always_comb begin
      out_mid.ax    = last.ax;
      out_mid.ay    = last.ay;
      out_mid.bx    = last.bx;
      out_mid.by    = last.by;
      out_mid.ma    = last.ma;
      out_mid.mb    = last.mb;
      out_mid.delta = last.delta;
      out_mid.hit   = last.hit;
      out_mid.nx    = last.near ? 17'(FxOne) : qx_ff[NormStages-1];
      out_mid.ny    = last.near ? 17'd0 : qy_ff[NormStages-1];
      out_mid.negx  = last.near ? 1'b0 : last.negx;
      out_mid.negy  = last.near ? 1'b0 : last.negy;
   end

   assign out_valid = vld_ff[NormStages-1];

endmodule

>>> src/ppcr_share.sv
// ppcr_share: mass split dividers, push products and saturating position update
// depends on ppcr_pkg

module ppcr_share import ppcr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  mid_type    in_mid,
   output logic       out_valid,
   output result_type out_res
);

   typedef struct packed {
      mid_type     mid;
      logic        infa;
      logic        infb;
      logic [31:0] tot;
      logic [63:0] pa;
      logic [63:0] pb;
   } sside_type;

   function automatic logic [31:0] sat36(input logic [35:0] v);
      logic [31:0] r;
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) r = v[31:0];
      else r = v[35] ? 32'h8000_0000 : 32'h7fff_ffff;
      return r;
   endfunction

   // products of push length and the other particle's mass
   logic      pv_ff;
   sside_type ps_ff;

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      ps_ff.mid  <= in_mid;
      ps_ff.infa <= in_mid.ma[31];
      ps_ff.infb <= in_mid.mb[31];
      ps_ff.tot  <= in_mid.ma + in_mid.mb;
      ps_ff.pa   <= 64'(in_mid.delta) * 64'(in_mid.mb[30:0]);
      ps_ff.pb   <= 64'(in_mid.delta) * 64'(in_mid.ma[30:0]);
   end

   // restoring dividers, one quotient bit per stage
   logic        vld_ff  [ShareStages];
   sside_type   side_ff [ShareStages];
   logic [31:0] ra_ff   [ShareStages];
   logic [31:0] rb_ff   [ShareStages];
   logic [32:0] qa_ff   [ShareStages];
   logic [32:0] qb_ff   [ShareStages];
   logic [31:0] ra_in   [ShareStages];
   logic [31:0] rb_in   [ShareStages];
   logic [32:0] qa_in   [ShareStages];
   logic [32:0] qb_in   [ShareStages];
   sside_type   side_in [ShareStages];

   always_comb begin
      sside_type   sd;
      logic [31:0] ra_p, rb_p;
      logic [32:0] qa_p, qb_p;
      logic [32:0] ta, tb, dv;
      for (int k = 0; k < ShareStages; k++) begin
         if (k == 0) begin
            sd   = ps_ff;
            ra_p = {1'b0, ps_ff.pa[63:33]};
            rb_p = {1'b0, ps_ff.pb[63:33]};
            qa_p = '0;
            qb_p = '0;
         end else begin
            sd   = side_ff[k-1];
            ra_p = ra_ff[k-1];
            rb_p = rb_ff[k-1];
            qa_p = qa_ff[k-1];
            qb_p = qb_ff[k-1];
         end
         dv = {1'b0, sd.tot};
         ta = {ra_p, sd.pa[ShareStages-1-k]};
         tb = {rb_p, sd.pb[ShareStages-1-k]};
         if (ta >= dv) begin
            ra_in[k] = 32'(ta - dv);
            qa_in[k] = {qa_p[31:0], 1'b1};
         end else begin
            ra_in[k] = ta[31:0];
            qa_in[k] = {qa_p[31:0], 1'b0};
         end
         if (tb >= dv) begin
            rb_in[k] = 32'(tb - dv);
            qb_in[k] = {qb_p[31:0], 1'b1};
         end else begin
            rb_in[k] = tb[31:0];
            qb_in[k] = {qb_p[31:0], 1'b0};
         end
         side_in[k] = sd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ShareStages; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < ShareStages; k++) vld_ff[k] <= (k == 0) ? pv_ff : vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ShareStages; k++) begin
         side_ff[k] <= side_in[k];
         ra_ff[k]   <= ra_in[k];
         rb_ff[k]   <= rb_in[k];
         qa_ff[k]   <= qa_in[k];
         qb_ff[k]   <= qb_in[k];
      end
   end

   // move selection: mass split quotients, or the immovable and massless cases
   sside_type   dl;
   logic        sv_ff, uv_ff, ov_ff;
   mid_type     sm_ff, um_ff;
   logic        sdone_ff, udone_ff;
   logic [32:0] mva_ff, mvb_ff;
   logic [33:0] pax_ff, pay_ff, pbx_ff, pby_ff;
   logic [32:0] mva_in, mvb_in;
   logic [49:0] prod_ax, prod_ay, prod_bx, prod_by;
   result_type  res_ff;

   assign dl = side_ff[ShareStages-1];

   always_comb begin
      if (dl.infa) begin
         mva_in = '0;
         mvb_in = dl.mid.delta;
      end else if (dl.infb) begin
         mva_in = dl.mid.delta;
         mvb_in = '0;
      end else if (dl.tot == 32'd0) begin
         mva_in = {1'b0, dl.mid.delta[32:1]};
         mvb_in = {1'b0, dl.mid.delta[32:1]};
      end else begin
         mva_in = qa_ff[ShareStages-1];
         mvb_in = qb_ff[ShareStages-1];
      end
   end

   assign prod_ax = 50'(sm_ff.nx) * 50'(mva_ff);
   assign prod_ay = 50'(sm_ff.ny) * 50'(mva_ff);
   assign prod_bx = 50'(sm_ff.nx) * 50'(mvb_ff);
   assign prod_by = 50'(sm_ff.ny) * 50'(mvb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
         uv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         sv_ff <= vld_ff[ShareStages-1];
         uv_ff <= sv_ff;
         ov_ff <= uv_ff;
      end
   end

   logic [35:0] eax, eay, ebx, eby;
   logic [35:0] new_ax, new_ay, new_bx, new_by;

   always_comb begin
      eax    = {2'b00, pax_ff};
      eay    = {2'b00, pay_ff};
      ebx    = {2'b00, pbx_ff};
      eby    = {2'b00, pby_ff};
      if (um_ff.negx) begin
         eax = 36'd0 - eax;
         ebx = 36'd0 - ebx;
      end
      if (um_ff.negy) begin
         eay = 36'd0 - eay;
         eby = 36'd0 - eby;
      end
      new_ax = {{4{um_ff.ax[31]}}, um_ff.ax} + eax;
      new_ay = {{4{um_ff.ay[31]}}, um_ff.ay} + eay;
      new_bx = {{4{um_ff.bx[31]}}, um_ff.bx} - ebx;
      new_by = {{4{um_ff.by[31]}}, um_ff.by} - eby;
   end

   always_ff @(posedge clock) begin
      sm_ff    <= dl.mid;
      sdone_ff <= dl.mid.hit && !(dl.infa && dl.infb);
      mva_ff   <= mva_in;
      mvb_ff   <= mvb_in;
      um_ff    <= sm_ff;
      udone_ff <= sdone_ff;
      pax_ff   <= prod_ax[49:16];
      pay_ff   <= prod_ay[49:16];
      pbx_ff   <= prod_bx[49:16];
      pby_ff   <= prod_by[49:16];
      if (udone_ff) begin
         res_ff.new_a_x <= sat36(new_ax);
         res_ff.new_a_y <= sat36(new_ay);
         res_ff.new_b_x <= sat36(new_bx);
         res_ff.new_b_y <= sat36(new_by);
      end else begin
         res_ff.new_a_x <= um_ff.ax;
         res_ff.new_a_y <= um_ff.ay;
         res_ff.new_b_x <= um_ff.bx;
         res_ff.new_b_y <= um_ff.by;
      end
      res_ff.corrected <= udone_ff;
   end

   assign out_valid = ov_ff;
   assign out_res   = res_ff;

endmodule

>>> src/particle_pair_collision_resolve.sv
// particle_pair_collision_resolve: top level, relaxation register and pipeline chain
// depends on ppcr_pkg, ppcr_front, ppcr_sqrt, ppcr_normal, ppcr_share
//
//   channel   ports                              handshake
//   -------   --------------------------------   -------------------------------
//   request   start, busy, req_data              taken when start && !busy
//   result    rsp_valid, rsp_data                one cycle strobe, never held off
//   config    psel penable pwrite paddr pwdata   write on psel&penable&pwrite
//             prdata pready                      pready always high
//
// one item enters every cycle
// the chain is 91 register stages: the bit-per-stage square root (32), the normal
// dividers (17), the mass split dividers (33), plus nine stages of multiply, compare
// and update
// reset clears the valid bits of every stage and loads relaxation with 0.1
// busy stays low: the pipeline never stalls and results go out as they finish

module particle_pair_collision_resolve import ppcr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  pair_type               req_data,
   // result channel
   output logic                   rsp_valid,
   output result_type             rsp_data,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // relaxation register, Q1.16, one means 65536
   logic [16:0] relax_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == RegRelaxation);
   assign prdata    = (paddr[2] == RegRelaxation) ? {15'd0, relax_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff <= RelaxReset;
      end else if (csr_write) begin
         relax_ff <= pwdata[16:0];
      end
   end

   // no back pressure anywhere in the chain
   assign busy = 1'b0;

   logic        front_valid, sqrt_valid, norm_valid;
   geo_type     front_geo, sqrt_geo;
   logic [31:0] sqrt_dist;
   mid_type     norm_mid;

   // differences, squares, overlap test
   ppcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_pair   (req_data),
      .out_valid (front_valid),
      .out_geo   (front_geo)
   );

   // floor distance between centres
   ppcr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_geo    (front_geo),
      .out_valid (sqrt_valid),
      .out_geo   (sqrt_geo),
      .out_dist  (sqrt_dist)
   );

   // push length and unit normal
   ppcr_normal u_normal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_geo    (sqrt_geo),
      .in_dist   (sqrt_dist),
      .relax     (relax_ff),
      .out_valid (norm_valid),
      .out_mid   (norm_mid)
   );

   // mass split and saturated positions, last stage is the output register
   ppcr_share u_share (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_mid    (norm_mid),
      .out_valid (rsp_valid),
      .out_res   (rsp_data)
   );

endmodule
